// ===== sv/eam_pkg.sv =====
// Shared types, constants and helper functions for the Euler-angle rotation matrix block.
// No dependencies; every other file imports this package.
package eam_pkg;

    localparam int ANGLE_BITS   = 32;
    localparam int ELEMENT_BITS = 32;
    localparam int CORDIC_STEPS = 28;

    localparam int INT_W      = 64;
    localparam int INT_FRAC   = 58;
    localparam int ANGLE_FRAC = ANGLE_BITS - 4;
    localparam int ELEM_FRAC  = ELEMENT_BITS - 2;
    localparam int ANG_SHIFT  = INT_FRAC - ANGLE_FRAC;
    localparam int ELEM_SHIFT = INT_FRAC - ELEM_FRAC;

    // |angle| never exceeds 2^61, so the quarter-turn count stays within five
    localparam int QUAD_MAX = 5;
    localparam int QK_W     = 3;

    localparam int SC_LAT   = CORDIC_STEPS + 3;
    localparam int ROT_LAT  = 5;
    localparam int PIPE_LAT = SC_LAT + 2 * ROT_LAT + 1;

    typedef logic signed [INT_W-1:0] ival_t;
    typedef ival_t [2:0][2:0] mat_t;

    localparam ival_t ONE_INT     = 64'sd1 <<< INT_FRAC;
    localparam ival_t HALF_PI     = 64'sh06487ED5110B4612;
    localparam ival_t QUARTER_PI  = 64'sh03243F6A8885A309;
    localparam ival_t CORDIC_GAIN = 64'sh026DD3B6A10D7969;

    localparam ival_t HP_MULT [0:QUAD_MAX] = '{
        64'sd0, HALF_PI, 2 * HALF_PI, 3 * HALF_PI, 4 * HALF_PI, 5 * HALF_PI
    };

    typedef enum logic [1:0] {
        AX_NONE,
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_NUM = 8'h31;
    localparam logic [7:0] CH_Y_UP  = 8'h59;
    localparam logic [7:0] CH_Y_LO  = 8'h79;
    localparam logic [7:0] CH_Y_NUM = 8'h32;
    localparam logic [7:0] CH_Z_UP  = 8'h5A;
    localparam logic [7:0] CH_Z_LO  = 8'h7A;
    localparam logic [7:0] CH_Z_NUM = 8'h33;

    typedef struct packed {
        logic [7:0]                   axis_char_first;
        logic [7:0]                   axis_char_second;
        logic [7:0]                   axis_char_third;
        logic signed [ANGLE_BITS-1:0] angle_first;
        logic signed [ANGLE_BITS-1:0] angle_second;
        logic signed [ANGLE_BITS-1:0] angle_third;
    } cmd_t;

    typedef struct packed {
        logic signed [ELEMENT_BITS-1:0] m_row0_col0;
        logic signed [ELEMENT_BITS-1:0] m_row0_col1;
        logic signed [ELEMENT_BITS-1:0] m_row0_col2;
        logic signed [ELEMENT_BITS-1:0] m_row1_col0;
        logic signed [ELEMENT_BITS-1:0] m_row1_col1;
        logic signed [ELEMENT_BITS-1:0] m_row1_col2;
        logic signed [ELEMENT_BITS-1:0] m_row2_col0;
        logic signed [ELEMENT_BITS-1:0] m_row2_col1;
        logic signed [ELEMENT_BITS-1:0] m_row2_col2;
    } result_t;

    function automatic axis_t axis_of(input logic [7:0] ch);
        axis_t r;
        case (ch) inside
            CH_X_UP, CH_X_LO, CH_X_NUM: r = AX_X;
            CH_Y_UP, CH_Y_LO, CH_Y_NUM: r = AX_Y;
            CH_Z_UP, CH_Z_LO, CH_Z_NUM: r = AX_Z;
            default:                    r = AX_NONE;
        endcase
        return r;
    endfunction

    // arctan(2^-i) by its power series, evaluated at elaboration only
    function automatic logic [63:0] atan_step(input int i);
        logic [63:0] pos;
        logic [63:0] negs;
        logic [63:0] t;
        int          k;
        pos  = '0;
        negs = '0;
        if (i == 0) begin
            return QUARTER_PI;
        end
        for (k = 0; i * (2 * k + 1) <= 62; k++) begin
            t = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
            if (k % 2 == 1) begin
                negs = negs + t;
            end else begin
                pos = pos + t;
            end
        end
        return (pos - negs + 64'd8) >> 4;
    endfunction

    function automatic ival_t sat_one(input ival_t v);
        ival_t r;
        if (v > ONE_INT) begin
            r = ONE_INT;
        end else if (v < -ONE_INT) begin
            r = -ONE_INT;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [INT_W-1:0] mag_of(input ival_t v);
        logic [INT_W-1:0] r;
        if (v < 0) begin
            r = INT_W'(-v);
        end else begin
            r = INT_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== sv/eam_sincos.sv =====
// Pipelined sine/cosine lane: quarter-turn range reduction, one CORDIC micro-rotation
// per stage, quadrant fold and saturation. Depends on eam_pkg.
module eam_sincos (
    input  logic                                 clk,
    input  logic signed [eam_pkg::ANGLE_BITS-1:0] angle,
    output eam_pkg::ival_t                       cos_val,
    output eam_pkg::ival_t                       sin_val
);
    import eam_pkg::*;

    ival_t            a_next;
    logic [QK_W-1:0]  k_next;
    ival_t            a_reg;
    logic [QK_W-1:0]  k_reg;
    ival_t            z0_next;
    logic [1:0]       q0_next;

    ival_t            x_reg [1:CORDIC_STEPS];
    ival_t            y_reg [1:CORDIC_STEPS];
    ival_t            z_reg [0:CORDIC_STEPS-1];
    logic [1:0]       q_reg [0:CORDIC_STEPS];

    ival_t            cx;
    ival_t            sy;
    ival_t            cos_reg;
    ival_t            sin_reg;

    // widen to 58 fraction bits and count whole quarter turns, truncating toward zero
    always_comb
    begin
        a_next = ival_t'({{(INT_W-ANGLE_BITS){angle[ANGLE_BITS-1]}}, angle}) <<< ANG_SHIFT;
        k_next = '0;
        for (int k = 1; k <= QUAD_MAX; k++)
        begin
            if (a_next >= 0 ? (a_next >= HP_MULT[k]) : (a_next <= -HP_MULT[k]))
            begin
                k_next = QK_W'(k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        k_reg <= k_next;
    end

    always_comb
    begin
        if (a_reg < 0)
        begin
            z0_next = a_reg + HP_MULT[k_reg];
            q0_next = ~k_reg[1:0] + 2'd1;
        end
        else
        begin
            z0_next = a_reg - HP_MULT[k_reg];
            q0_next = k_reg[1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg[0] <= z0_next;
        q_reg[0] <= q0_next;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam ival_t ATAN_I = ival_t'(atan_step(i));
        ival_t xi;
        ival_t yi;

        if (i == 0)
        begin : g_first
            assign xi = CORDIC_GAIN;
            assign yi = '0;
        end
        else
        begin : g_rest
            assign xi = x_reg[i];
            assign yi = y_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (z_reg[i] >= 0)
            begin
                x_reg[i+1] <= xi - (yi >>> i);
                y_reg[i+1] <= yi + (xi >>> i);
            end
            else
            begin
                x_reg[i+1] <= xi + (yi >>> i);
                y_reg[i+1] <= yi - (xi >>> i);
            end
            q_reg[i+1] <= q_reg[i];
        end

        if (i < CORDIC_STEPS - 1)
        begin : g_z
            always_ff @(posedge clk)
            begin
                if (z_reg[i] >= 0)
                begin
                    z_reg[i+1] <= z_reg[i] - ATAN_I;
                end
                else
                begin
                    z_reg[i+1] <= z_reg[i] + ATAN_I;
                end
            end
        end
    end

    // fold the quarter turns back in
    always_comb
    begin
        case (q_reg[CORDIC_STEPS])
            2'd0:
            begin
                cx = x_reg[CORDIC_STEPS];
                sy = y_reg[CORDIC_STEPS];
            end
            2'd1:
            begin
                cx = -y_reg[CORDIC_STEPS];
                sy = x_reg[CORDIC_STEPS];
            end
            2'd2:
            begin
                cx = -x_reg[CORDIC_STEPS];
                sy = -y_reg[CORDIC_STEPS];
            end
            default:
            begin
                cx = y_reg[CORDIC_STEPS];
                sy = -x_reg[CORDIC_STEPS];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= sat_one(cx);
        sin_reg <= sat_one(sy);
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

// ===== sv/eam_rotate.sv =====
// Five-stage left multiplication of the running matrix by one elementary axis rotation,
// with 32x32 partial products and half-away-from-zero rounding. Depends on eam_pkg.
module eam_rotate (
    input  logic            clk,
    input  eam_pkg::ival_t  c,
    input  eam_pkg::ival_t  s,
    input  eam_pkg::axis_t  axis,
    input  logic            apply,
    input  eam_pkg::mat_t   m_in,
    output eam_pkg::mat_t   m_out
);
    import eam_pkg::*;

    typedef struct packed {
        mat_t       m;
        logic [1:0] ra;
        logic [1:0] rb;
        logic       ap;
    } side_t;

    logic [1:0]        ra;
    logic [1:0]        rb;
    logic              sg_neg;

    side_t             side_reg [1:4];
    logic [INT_W-1:0]  cm_reg;
    logic [INT_W-1:0]  sm_reg;
    logic              cn_reg;
    logic              sn_reg;
    logic              sgn_reg;
    logic [INT_W-1:0]  am_reg [3];
    logic [INT_W-1:0]  bm_reg [3];
    logic              an_reg [3];
    logic              bn_reg [3];

    logic [63:0]       pp_reg  [4][3][4];
    logic              ng2_reg [4][3];
    logic [INT_W-1:0]  mg3_reg [4][3];
    logic              ng3_reg [4][3];
    ival_t             tm4_reg [4][3];

    mat_t              mo_next;
    mat_t              mo_reg;

    // rows touched by the rotation, and which cross term carries the minus sign
    always_comb
    begin
        case (axis)
            AX_X:
            begin
                ra = 2'd1;
                rb = 2'd2;
                sg_neg = 1'b0;
            end
            AX_Y:
            begin
                ra = 2'd0;
                rb = 2'd2;
                sg_neg = 1'b1;
            end
            AX_Z:
            begin
                ra = 2'd0;
                rb = 2'd1;
                sg_neg = 1'b0;
            end
            default:
            begin
                ra = 2'd1;
                rb = 2'd2;
                sg_neg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        side_reg[1] <= '{m: m_in, ra: ra, rb: rb, ap: apply};
        for (int n = 2; n <= 4; n++)
        begin
            side_reg[n] <= side_reg[n-1];
        end
        cm_reg  <= mag_of(c);
        sm_reg  <= mag_of(s);
        cn_reg  <= c < 0;
        sn_reg  <= s < 0;
        sgn_reg <= sg_neg;
        for (int j = 0; j < 3; j++)
        begin
            am_reg[j] <= mag_of(m_in[ra][j]);
            bm_reg[j] <= mag_of(m_in[rb][j]);
            an_reg[j] <= m_in[ra][j] < 0;
            bn_reg[j] <= m_in[rb][j] < 0;
        end
    end

    // products: 0 = c*ma, 1 = s*mb, 2 = s*ma, 3 = c*mb
    for (genvar p = 0; p < 4; p++)
    begin : g_prod
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            logic [INT_W-1:0] opl;
            logic [INT_W-1:0] opr;
            logic             ng;
            logic [127:0]     sum;

            always_comb
            begin
                opl = (p == 0 || p == 3) ? cm_reg : sm_reg;
                opr = (p == 0 || p == 2) ? am_reg[j] : bm_reg[j];
                ng  = ((p == 0 || p == 3) ? cn_reg : sn_reg)
                    ^ ((p == 0 || p == 2) ? an_reg[j] : bn_reg[j]);
                if (p == 1)
                begin
                    ng = ng ^ sgn_reg;
                end
                else if (p == 2)
                begin
                    ng = ng ^ ~sgn_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                pp_reg[p][j][0] <= 64'(opl[31:0])  * 64'(opr[31:0]);
                pp_reg[p][j][1] <= 64'(opl[31:0])  * 64'(opr[63:32]);
                pp_reg[p][j][2] <= 64'(opl[63:32]) * 64'(opr[31:0]);
                pp_reg[p][j][3] <= 64'(opl[63:32]) * 64'(opr[63:32]);
                ng2_reg[p][j]   <= ng;
            end

            assign sum = {pp_reg[p][j][3], pp_reg[p][j][0]}
                       + ({64'd0, pp_reg[p][j][1]} << 32)
                       + ({64'd0, pp_reg[p][j][2]} << 32)
                       + (128'd1 << (INT_FRAC - 1));

            always_ff @(posedge clk)
            begin
                mg3_reg[p][j] <= sum[INT_FRAC +: INT_W];
                ng3_reg[p][j] <= ng2_reg[p][j];
                if (ng3_reg[p][j])
                begin
                    tm4_reg[p][j] <= -ival_t'(mg3_reg[p][j]);
                end
                else
                begin
                    tm4_reg[p][j] <= ival_t'(mg3_reg[p][j]);
                end
            end
        end
    end

    always_comb
    begin
        mo_next = side_reg[4].m;
        if (side_reg[4].ap)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mo_next[side_reg[4].ra][j] = sat_one(tm4_reg[0][j] + tm4_reg[1][j]);
                mo_next[side_reg[4].rb][j] = sat_one(tm4_reg[2][j] + tm4_reg[3][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mo_reg <= mo_next;
    end

    assign m_out = mo_reg;

endmodule

// ===== sv/euler_angles_to_rotation_matrix.sv =====
// Top level of the Euler-angle direction cosine matrix block.
// Depends on eam_pkg, eam_sincos and eam_rotate.
//
// One transaction enters per clock cycle and its matrix appears on result, marked by done,
// after the sine/cosine lanes with their 28 CORDIC stages, two five-stage rotation products
// and an output register. busy stays low, and the receiver must take every result in the
// cycle that done is high. The three sine/cosine lanes run side by side; the first rotation
// needs no multiply.
module euler_angles_to_rotation_matrix (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  eam_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done,
    output eam_pkg::result_t result
);
    import eam_pkg::*;

    typedef struct packed {
        axis_t a1;
        axis_t a2;
        axis_t a3;
    } axes_t;

    typedef struct packed {
        ival_t c;
        ival_t s;
        axis_t ax;
        logic  ap;
    } third_t;

    logic      accept;
    logic      vld_reg [0:PIPE_LAT-1];
    axes_t     axd_reg [0:SC_LAT-1];
    third_t    l3_reg  [1:ROT_LAT];

    ival_t     c1, s1, c2, s2, c3, s3;
    logic      act1, act2, act3;
    mat_t      m1, m2, m3;
    result_t   res_next;
    result_t   res_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < PIPE_LAT; n++)
            begin
                vld_reg[n] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int n = 1; n < PIPE_LAT; n++)
            begin
                vld_reg[n] <= vld_reg[n-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        axd_reg[0] <= '{a1: axis_of(cmd.axis_char_first),
                        a2: axis_of(cmd.axis_char_second),
                        a3: axis_of(cmd.axis_char_third)};
        for (int n = 1; n < SC_LAT; n++)
        begin
            axd_reg[n] <= axd_reg[n-1];
        end
    end

    eam_sincos u_sc1 (.clk(clk), .angle(cmd.angle_first),  .cos_val(c1), .sin_val(s1));
    eam_sincos u_sc2 (.clk(clk), .angle(cmd.angle_second), .cos_val(c2), .sin_val(s2));
    eam_sincos u_sc3 (.clk(clk), .angle(cmd.angle_third),  .cos_val(c3), .sin_val(s3));

    // an unknown code stops the sequence: later slots drop out
    assign act1 = axd_reg[SC_LAT-1].a1 != AX_NONE;
    assign act2 = act1 && (axd_reg[SC_LAT-1].a2 != AX_NONE);
    assign act3 = act2 && (axd_reg[SC_LAT-1].a3 != AX_NONE);

    // first rotation applied to the identity is the elementary matrix itself
    always_comb
    begin
        m1 = '0;
        m1[0][0] = ONE_INT;
        m1[1][1] = ONE_INT;
        m1[2][2] = ONE_INT;
        case (act1 ? axd_reg[SC_LAT-1].a1 : AX_NONE)
            AX_X:
            begin
                m1[1][1] = c1;
                m1[1][2] = s1;
                m1[2][1] = -s1;
                m1[2][2] = c1;
            end
            AX_Y:
            begin
                m1[0][0] = c1;
                m1[0][2] = -s1;
                m1[2][0] = s1;
                m1[2][2] = c1;
            end
            AX_Z:
            begin
                m1[0][0] = c1;
                m1[0][1] = s1;
                m1[1][0] = -s1;
                m1[1][1] = c1;
            end
            default:
            begin
                m1[0][0] = ONE_INT;
            end
        endcase
    end

    eam_rotate u_rot2 (
        .clk   (clk),
        .c     (c2),
        .s     (s2),
        .axis  (axd_reg[SC_LAT-1].a2),
        .apply (act2),
        .m_in  (m1),
        .m_out (m2)
    );

    // hold the third angle until the second product is out
    always_ff @(posedge clk)
    begin
        l3_reg[1] <= '{c: c3, s: s3, ax: axd_reg[SC_LAT-1].a3, ap: act3};
        for (int n = 2; n <= ROT_LAT; n++)
        begin
            l3_reg[n] <= l3_reg[n-1];
        end
    end

    eam_rotate u_rot3 (
        .clk   (clk),
        .c     (l3_reg[ROT_LAT].c),
        .s     (l3_reg[ROT_LAT].s),
        .axis  (l3_reg[ROT_LAT].ax),
        .apply (l3_reg[ROT_LAT].ap),
        .m_in  (m2),
        .m_out (m3)
    );

    function automatic logic signed [ELEMENT_BITS-1:0] to_elem(input ival_t v);
        ival_t r;
        r = (v + (64'sd1 <<< (ELEM_SHIFT - 1))) >>> ELEM_SHIFT;
        if (r > (64'sd1 <<< ELEM_FRAC))
        begin
            r = 64'sd1 <<< ELEM_FRAC;
        end
        else if (r < -(64'sd1 <<< ELEM_FRAC))
        begin
            r = -(64'sd1 <<< ELEM_FRAC);
        end
        return r[ELEMENT_BITS-1:0];
    endfunction

    always_comb
    begin
        res_next.m_row0_col0 = to_elem(m3[0][0]);
        res_next.m_row0_col1 = to_elem(m3[0][1]);
        res_next.m_row0_col2 = to_elem(m3[0][2]);
        res_next.m_row1_col0 = to_elem(m3[1][0]);
        res_next.m_row1_col1 = to_elem(m3[1][1]);
        res_next.m_row1_col2 = to_elem(m3[1][2]);
        res_next.m_row2_col0 = to_elem(m3[2][0]);
        res_next.m_row2_col1 = to_elem(m3[2][1]);
        res_next.m_row2_col2 = to_elem(m3[2][2]);
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result = res_reg;
    assign done   = vld_reg[PIPE_LAT-1];

endmodule

// ===== sv/eam_checker.sv =====
// Port-level checks for the Euler-angle rotation matrix block, bound to the top level.
// Depends on eam_pkg and euler_angles_to_rotation_matrix.
module eam_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input eam_pkg::cmd_t    cmd,
    input logic             busy,
    input logic             done,
    input eam_pkg::result_t result
);
    import eam_pkg::*;

    localparam logic signed [ELEMENT_BITS-1:0] E_ONE = ELEMENT_BITS'(64'sd1 <<< ELEM_FRAC);

    logic first_none;
    logic in_range;
    logic is_ident;

    assign first_none = axis_of(cmd.axis_char_first) == AX_NONE;

    always_comb
    begin
        in_range = 1'b1;
        for (int n = 0; n < 9; n++)
        begin
            if ($signed(result[n*ELEMENT_BITS +: ELEMENT_BITS]) > E_ONE ||
                $signed(result[n*ELEMENT_BITS +: ELEMENT_BITS]) < -E_ONE)
            begin
                in_range = 1'b0;
            end
        end
        is_ident = result.m_row0_col0 == E_ONE && result.m_row1_col1 == E_ONE &&
                   result.m_row2_col2 == E_ONE && result.m_row0_col1 == '0 &&
                   result.m_row0_col2 == '0 && result.m_row1_col0 == '0 &&
                   result.m_row1_col2 == '0 && result.m_row2_col0 == '0 &&
                   result.m_row2_col1 == '0;
    end

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(PIPE_LAT) done)
        else $error("result missing after accepted transaction");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without transaction");

    a_range: assert property (@(posedge clk) disable iff (!rst_n) done |-> in_range)
        else $error("matrix element outside unit range");

    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(first_none, PIPE_LAT) |-> is_ident)
        else $error("no rotation but result is not identity");

endmodule

bind euler_angles_to_rotation_matrix eam_checker u_eam_checker (.*);
